>>> src/date_add_days_core_defines.svh
// assertion macros shared by the date adder modules
`ifndef DATE_ADD_DAYS_CORE_DEFINES_SVH
`define DATE_ADD_DAYS_CORE_DEFINES_SVH

// check sampled on the rising edge, masked while reset is held
`define DAD_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("%m: check failed");

// check that also covers the reset cycles
`define DAD_ASSERT_RST(name, prop) \
    name: assert property (@(posedge aclk) prop) \
        else $error("%m: reset check failed");

`endif

>>> src/dad_pkg.sv
`default_nettype none

package dad_pkg;

    // field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 16;
    localparam int OFFSET_W = 16;
    // working day count: day plus offset, signed
    localparam int ACC_W    = OFFSET_W + 1;

    // calendar constants
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS   = 5'd29;
    localparam logic [DAY_W-1:0]   FEB_COMMON_DAYS = 5'd28;
    localparam logic [DAY_W-1:0]   LONG_MONTH_DAYS = 5'd31;
    localparam logic [DAY_W-1:0]   SHORT_MONTH_DAYS = 5'd30;

    // controller states
    typedef enum logic [0:0] {
        DAD_IDLE,
        DAD_RUN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
    } status_t;

    // days in a month, julian leap rule
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd2: begin
                len = leap ? FEB_LEAP_DAYS : FEB_COMMON_DAYS;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = SHORT_MONTH_DAYS;
            end
            default: begin
                len = LONG_MONTH_DAYS;
            end
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> src/dad_datapath.sv
`default_nettype none
`include "date_add_days_core_defines.svh"

module dad_datapath (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire dad_pkg::cmd_t                          cmd,
    output dad_pkg::status_t                            status,
    input  wire logic        [dad_pkg::DAY_W-1:0]       s_start_day,
    input  wire logic        [dad_pkg::MONTH_W-1:0]     s_start_month,
    input  wire logic signed [dad_pkg::YEAR_W-1:0]      s_start_year,
    input  wire logic signed [dad_pkg::OFFSET_W-1:0]    s_day_offset,
    output logic             [dad_pkg::DAY_W-1:0]       m_result_day,
    output logic             [dad_pkg::MONTH_W-1:0]     m_result_month,
    output logic signed      [dad_pkg::YEAR_W-1:0]      m_result_year
);

    localparam int PAD_W = dad_pkg::ACC_W - dad_pkg::DAY_W;

    logic signed [dad_pkg::ACC_W-1:0]   day_reg, day_next;
    logic        [dad_pkg::MONTH_W-1:0] month_reg, month_next;
    logic        [dad_pkg::YEAR_W-1:0]  year_reg, year_next;
    logic        [dad_pkg::DAY_W-1:0]   out_day_reg;
    logic        [dad_pkg::MONTH_W-1:0] out_month_reg;
    logic        [dad_pkg::YEAR_W-1:0]  out_year_reg;

    logic                               leap;
    logic        [dad_pkg::MONTH_W-1:0] prev_month;
    logic        [dad_pkg::DAY_W-1:0]   len_cur;
    logic        [dad_pkg::DAY_W-1:0]   len_prev;
    logic signed [dad_pkg::ACC_W-1:0]   len_cur_s;
    logic signed [dad_pkg::ACC_W-1:0]   len_prev_s;
    logic                               over;
    logic                               under;
    logic        [dad_pkg::MONTH_W-1:0] load_month;

    // month lengths around the current month
    always_comb begin
        leap       = (year_reg[1:0] == 2'b00);
        prev_month = (month_reg == dad_pkg::MONTH_JAN) ? dad_pkg::MONTH_DEC
                                                       : month_reg - 4'd1;
        len_cur    = dad_pkg::month_len(month_reg, leap);
        len_prev   = dad_pkg::month_len(prev_month, leap);
        len_cur_s  = $signed({{PAD_W{1'b0}}, len_cur});
        len_prev_s = $signed({{PAD_W{1'b0}}, len_prev});
        over       = (day_reg > len_cur_s);
        under      = (day_reg <= $signed({dad_pkg::ACC_W{1'b0}}));
        status.done = !over && !under;
    end

    // start month saturated into january..december
    always_comb begin
        if (s_start_month < dad_pkg::MONTH_JAN) begin
            load_month = dad_pkg::MONTH_JAN;
        end else if (s_start_month > dad_pkg::MONTH_DEC) begin
            load_month = dad_pkg::MONTH_DEC;
        end else begin
            load_month = s_start_month;
        end
    end

    // one month carry or borrow per step
    always_comb begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        if (cmd.load) begin
            day_next   = $signed({{PAD_W{1'b0}}, s_start_day})
                       + $signed({s_day_offset[dad_pkg::OFFSET_W-1], s_day_offset});
            month_next = load_month;
            year_next  = s_start_year;
        end else if (cmd.step) begin
            if (over) begin
                day_next = day_reg - len_cur_s;
                if (month_reg == dad_pkg::MONTH_DEC) begin
                    month_next = dad_pkg::MONTH_JAN;
                    year_next  = year_reg + 16'd1;
                end else begin
                    month_next = month_reg + 4'd1;
                end
            end else if (under) begin
                day_next   = day_reg + len_prev_s;
                month_next = prev_month;
                if (month_reg == dad_pkg::MONTH_JAN) begin
                    year_next = year_reg - 16'd1;
                end
            end
        end
    end

    // working registers and result word
    always_ff @(posedge aclk) begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        if (cmd.commit) begin
            out_day_reg   <= day_reg[dad_pkg::DAY_W-1:0];
            out_month_reg <= month_reg;
            out_year_reg  <= year_reg;
        end
    end

    assign m_result_day   = out_day_reg;
    assign m_result_month = out_month_reg;
    assign m_result_year  = $signed(out_year_reg);

    // a committed date is normalized
    `DAD_ASSERT(a_commit_month, cmd.commit |-> (month_reg >= dad_pkg::MONTH_JAN && month_reg <= dad_pkg::MONTH_DEC))
    `DAD_ASSERT(a_commit_day, cmd.commit |-> (day_reg > 0 && day_reg <= len_cur_s))
    // the result word changes only on commit
    `DAD_ASSERT(a_out_hold, !$past(cmd.commit) |-> $stable(out_day_reg))

endmodule

`default_nettype wire

>>> src/dad_ctrl.sv
`default_nettype none
`include "date_add_days_core_defines.svh"

module dad_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output dad_pkg::cmd_t         cmd,
    input  wire dad_pkg::status_t status
);

    dad_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    // state and result valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dad_pkg::DAD_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            dad_pkg::DAD_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = dad_pkg::DAD_RUN;
                end
            end
            dad_pkg::DAD_RUN: begin
                if (!status.done) begin
                    cmd.step = 1'b1;
                end else if (!out_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = dad_pkg::DAD_IDLE;
                end
            end
            default: begin
                state_next = dad_pkg::DAD_IDLE;
            end
        endcase
    end

    // result word stays offered until taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end
    end

    assign m_valid = out_valid_reg;

    `DAD_ASSERT_RST(a_reset_clear, !aresetn |=> (state_reg == dad_pkg::DAD_IDLE && !out_valid_reg))
    `DAD_ASSERT(a_commit_free, cmd.commit |-> (!out_valid_reg || m_ready))
    `DAD_ASSERT(a_load_runs, cmd.load |=> (state_reg == dad_pkg::DAD_RUN))
    `DAD_ASSERT(a_commit_valid, cmd.commit |=> m_valid)

endmodule

`default_nettype wire

>>> src/date_add_days_core.sv
// date adder: one month of carry or borrow per cycle
// a date is loaded, stepped one month at a time until normalized, then committed once the output is free
// one date at a time: a new date is taken only after the last one is committed
// a finished result waits in an output register while the next date is taken
// reset (aresetn low, synchronous) returns to idle and drops the result valid
`default_nettype none

module date_add_days_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic        [dad_pkg::DAY_W-1:0]    s_start_day,
    input  wire logic        [dad_pkg::MONTH_W-1:0]  s_start_month,
    input  wire logic signed [dad_pkg::YEAR_W-1:0]   s_start_year,
    input  wire logic signed [dad_pkg::OFFSET_W-1:0] s_day_offset,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic             [dad_pkg::DAY_W-1:0]    m_result_day,
    output logic             [dad_pkg::MONTH_W-1:0]  m_result_month,
    output logic signed      [dad_pkg::YEAR_W-1:0]   m_result_year
);

    dad_pkg::cmd_t    cmd;
    dad_pkg::status_t status;

    // sequencer
    dad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // date registers and month step
    dad_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_start_day    (s_start_day),
        .s_start_month  (s_start_month),
        .s_start_year   (s_start_year),
        .s_day_offset   (s_day_offset),
        .m_result_day   (m_result_day),
        .m_result_month (m_result_month),
        .m_result_year  (m_result_year)
    );

endmodule

`default_nettype wire

>>> bench/date_add_days_core_test.sv
`timescale 1ns / 100ps

module date_add_days_core_test;

    localparam int NUM_RANDOM   = 520;
    localparam int QUIET_TAIL   = 60;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT      = 120;
    localparam int DRAIN_AT     = 260;
    localparam int MAX_REPORTS  = 10;
    localparam int SETTLE_WAIT  = 40;

    // one calendar date at the block's widths
    typedef struct packed {
        logic [dad_pkg::DAY_W-1:0]   day;
        logic [dad_pkg::MONTH_W-1:0] month;
        logic [dad_pkg::YEAR_W-1:0]  year;
    } date_t;

    // one row of the directed stimulus
    typedef struct packed {
        logic [dad_pkg::DAY_W-1:0]    day;
        logic [dad_pkg::MONTH_W-1:0]  month;
        logic [dad_pkg::YEAR_W-1:0]   year;
        logic [dad_pkg::OFFSET_W-1:0] offset;
        logic                         typed;
        date_t                        want;
    } dir_row_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic [dad_pkg::DAY_W-1:0]           s_start_day;
    logic [dad_pkg::MONTH_W-1:0]         s_start_month;
    logic signed [dad_pkg::YEAR_W-1:0]   s_start_year;
    logic signed [dad_pkg::OFFSET_W-1:0] s_day_offset;
    logic                                m_valid;
    logic                                m_ready;
    logic [dad_pkg::DAY_W-1:0]           m_result_day;
    logic [dad_pkg::MONTH_W-1:0]         m_result_month;
    logic signed [dad_pkg::YEAR_W-1:0]   m_result_year;

    date_t pending_dates [$];
    int    mismatch_count = 0;
    bit    quiet_tail     = 1'b0;
    bit    hold_off_req   = 1'b0;

    date_add_days_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_day    (s_start_day),
        .s_start_month  (s_start_month),
        .s_start_year   (s_start_year),
        .s_day_offset   (s_day_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_day   (m_result_day),
        .m_result_month (m_result_month),
        .m_result_year  (m_result_year)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // month length, julian leap years on the low two year bits
    function automatic int days_in_month(input logic [dad_pkg::MONTH_W-1:0] mon,
                                         input logic [dad_pkg::YEAR_W-1:0] yr);
        if (mon == dad_pkg::MONTH_FEB && yr[1:0] == 2'b00)
            return 29;
        if (mon == dad_pkg::MONTH_FEB)
            return 28;
        if (mon == 4'd4 || mon == 4'd6 || mon == 4'd9 || mon == 4'd11)
            return 30;
        return 31;
    endfunction

    // normalized date after adding the offset, one month per pass
    function automatic date_t advance_date(input logic [dad_pkg::DAY_W-1:0] sday,
                                           input logic [dad_pkg::MONTH_W-1:0] smon,
                                           input logic [dad_pkg::YEAR_W-1:0] syear,
                                           input logic signed [dad_pkg::OFFSET_W-1:0] off);
        int                          day;
        int                          len;
        logic [dad_pkg::MONTH_W-1:0] mon;
        logic [dad_pkg::YEAR_W-1:0]  yr;
        bit                          settled;
        date_t                       res;
        // out-of-range months saturate
        if (smon < dad_pkg::MONTH_JAN)
            mon = dad_pkg::MONTH_JAN;
        else if (smon > dad_pkg::MONTH_DEC)
            mon = dad_pkg::MONTH_DEC;
        else
            mon = smon;
        yr = syear;
        day = int'(sday) + int'(off);
        settled = 1'b0;
        while (!settled) begin
            len = days_in_month(mon, yr);
            if (day > len) begin
                // carry into the next month
                day -= len;
                if (mon == dad_pkg::MONTH_DEC) begin
                    mon = dad_pkg::MONTH_JAN;
                    yr = yr + 1'b1;
                end else begin
                    mon = mon + 1'b1;
                end
            end else if (day <= 0) begin
                // borrow from the previous month
                if (mon == dad_pkg::MONTH_JAN) begin
                    mon = dad_pkg::MONTH_DEC;
                    yr = yr - 1'b1;
                end else begin
                    mon = mon - 1'b1;
                end
                day += days_in_month(mon, yr);
            end else begin
                settled = 1'b1;
            end
        end
        res.day = day[dad_pkg::DAY_W-1:0];
        res.month = mon;
        res.year = yr;
        return res;
    endfunction

    function automatic dir_row_t mk_row(input logic [dad_pkg::DAY_W-1:0] d,
                                        input logic [dad_pkg::MONTH_W-1:0] m,
                                        input logic [dad_pkg::YEAR_W-1:0] y,
                                        input logic [dad_pkg::OFFSET_W-1:0] off,
                                        input logic typed,
                                        input logic [dad_pkg::DAY_W-1:0] wd,
                                        input logic [dad_pkg::MONTH_W-1:0] wm,
                                        input logic [dad_pkg::YEAR_W-1:0] wy);
        dir_row_t r;
        r.day = d;
        r.month = m;
        r.year = y;
        r.offset = off;
        r.typed = typed;
        r.want.day = wd;
        r.want.month = wm;
        r.want.year = wy;
        return r;
    endfunction

    // offer one word and queue its expected date once taken
    task automatic send_date(input logic [dad_pkg::DAY_W-1:0] d,
                             input logic [dad_pkg::MONTH_W-1:0] m,
                             input logic [dad_pkg::YEAR_W-1:0] y,
                             input logic [dad_pkg::OFFSET_W-1:0] off,
                             input logic typed, input date_t want);
        s_valid <= 1'b1;
        s_start_day <= d;
        s_start_month <= m;
        s_start_year <= y;
        s_day_offset <= off;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (typed)
            pending_dates.push_back(want);
        else
            pending_dates.push_back(advance_date(d, m, y, off));
    endtask

    // stimulus and end of run
    initial begin : stimulus
        dir_row_t                     dir_tab [$];
        logic [dad_pkg::DAY_W-1:0]    d;
        logic [dad_pkg::MONTH_W-1:0]  m;
        logic [dad_pkg::YEAR_W-1:0]   y;
        logic [dad_pkg::OFFSET_W-1:0] off;
        int                           sel;
        int                           i;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_start_day <= '0;
        s_start_month <= '0;
        s_start_year <= '0;
        s_day_offset <= '0;

        // plain dates, wraps, leap years and malformed inputs
        dir_tab.push_back(mk_row(1, 1, 2000, 0, 1, 1, 1, 2000));
        dir_tab.push_back(mk_row(31, 12, 32767, 1, 1, 1, 1, -32768));
        dir_tab.push_back(mk_row(1, 1, -32768, -1, 1, 31, 12, 32767));
        dir_tab.push_back(mk_row(1, 1, -32768, 0, 1, 1, 1, -32768));
        dir_tab.push_back(mk_row(29, 2, 2024, 0, 1, 29, 2, 2024));
        dir_tab.push_back(mk_row(28, 2, 2023, 1, 1, 1, 3, 2023));
        dir_tab.push_back(mk_row(28, 2, 2024, 1, 1, 29, 2, 2024));
        dir_tab.push_back(mk_row(1, 3, 2024, -1, 1, 29, 2, 2024));
        dir_tab.push_back(mk_row(28, 2, -1, 1, 1, 1, 3, -1));
        dir_tab.push_back(mk_row(28, 2, -4, 1, 1, 29, 2, -4));
        dir_tab.push_back(mk_row(0, 3, 2023, 0, 1, 28, 2, 2023));
        dir_tab.push_back(mk_row(0, 1, 2023, 0, 1, 31, 12, 2022));
        dir_tab.push_back(mk_row(31, 4, 2023, 0, 1, 1, 5, 2023));
        dir_tab.push_back(mk_row(31, 2, 2024, 0, 1, 2, 3, 2024));
        dir_tab.push_back(mk_row(15, 0, 2023, 0, 1, 15, 1, 2023));
        dir_tab.push_back(mk_row(15, 13, 2023, 0, 1, 15, 12, 2023));
        dir_tab.push_back(mk_row(15, 15, 2023, 0, 1, 15, 12, 2023));
        dir_tab.push_back(mk_row(0, 15, 100, 0, 1, 30, 11, 100));
        dir_tab.push_back(mk_row(1, 1, 2000, 32767, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(31, 12, 2000, -32768, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(31, 1, 32767, 32767, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 1, -32768, -32768, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(30, 2, 2023, -30, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(31, 15, -2, 400, 0, 0, 0, 0));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        for (i = 0; i < dir_tab.size(); i++) begin
            send_date(dir_tab[i].day, dir_tab[i].month, dir_tab[i].year,
                      dir_tab[i].offset, dir_tab[i].typed, dir_tab[i].want);
            if ($urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end

        // random part
        for (i = 0; i < NUM_RANDOM; i++) begin
            if (i == NUM_RANDOM - QUIET_TAIL)
                quiet_tail = 1'b1;
            // long output stall while words keep coming
            if (i == HOLD_AT)
                hold_off_req = 1'b1;

            y = 16'($urandom);
            if ($urandom_range(0, 7) == 0)
                y = $urandom_range(0, 1) ? 16'h7FFF - 16'($urandom_range(0, 3))
                                         : 16'h8000 + 16'($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 8) begin
                m = 4'($urandom_range(1, 12));
                d = 5'($urandom_range(1, days_in_month(m, y)));
            end else begin
                m = 4'($urandom_range(0, 15));
                d = 5'($urandom_range(0, 31));
            end
            // mostly short offsets, a few across the whole range
            sel = $urandom_range(0, 9);
            if (sel < 7)
                off = 16'($urandom_range(0, 800) - 400);
            else if (sel < 9)
                off = 16'($urandom_range(0, 8000) - 4000);
            else
                off = 16'($urandom);

            send_date(d, m, y, off, 1'b0, '0);

            if (i == DRAIN_AT) begin
                // let the block empty out completely
                s_valid <= 1'b0;
                while (pending_dates.size() != 0)
                    @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        // drain and settle
        while (pending_dates.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);

        if (mismatch_count == 0 && pending_dates.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // result side ready, random stalls and one long hold-off
    initial begin : sink
        int n;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                for (n = 0; n < LONG_HOLD; n++)
                    @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // compare each result word with the oldest expected date
    always @(posedge aclk) begin : result_check
        date_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_dates.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result word: %0d/%0d/%0d",
                             m_result_day, m_result_month, m_result_year);
            end else begin
                want = pending_dates.pop_front();
                if (m_result_day !== want.day || m_result_month !== want.month ||
                    m_result_year !== want.year) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("date mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.day, want.month, $signed(want.year),
                                 m_result_day, m_result_month, m_result_year);
                end
            end
        end
    end

endmodule

>>> sim.f
+incdir+src
src/dad_pkg.sv
src/dad_datapath.sv
src/dad_ctrl.sv
src/date_add_days_core.sv
bench/date_add_days_core_test.sv
